/* sv/multi_queue_tx_message_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue transmit message FIFO
// Shared concurrent check forms, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_TX_MESSAGE_FIFO_DEFINES_SVH
`define MULTI_QUEUE_TX_MESSAGE_FIFO_DEFINES_SVH

// same-cycle implication
`define MQTX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQTX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mqtx_pkg.sv */
// ----------------------------------------------------------------------------
// mqtx_pkg
// Field widths, codes and result type of the multi-queue transmit FIFO.
// ----------------------------------------------------------------------------
package mqtx_pkg;

  localparam int ID_W        = 11;
  localparam int PAYLOAD_W   = 64;
  localparam int QSEL_W      = 2;
  localparam int DEPTH_CFG_W = 5;
  localparam int ACTIVE_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_QUEUES = 1'b1;

  localparam logic [DEPTH_CFG_W-1:0] QUEUE_DEPTH_RST   = 5'd10;
  localparam logic [ACTIVE_W-1:0]    ACTIVE_QUEUES_RST = 2'd3;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DRAIN   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_MSG    = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [QSEL_W-1:0]     qnum;
    logic [ID_W-1:0]       id;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  refused;
    logic                  last;
  } res_t;

endpackage

/* sv/multi_queue_tx_message_fifo.sv */
// Enqueue: the status beat passes the pointer decode and emit states, then the
//   output register (a nonexistent queue skips pointer decode); the next item
//   is taken only after the sequencer is back in idle. Drain: a pointer read
//   per visited queue, plus a message RAM read per queue that yields a message.
// Output stalls hold the sequencer in place.
// Reset (rst_n low, synchronous): pointers read as zero, config 10 / 3.
// ----------------------------------------------------------------------------
// multi_queue_tx_message_fifo
// Several ring queues of CAN messages held in a message RAM, with per-queue
// head/tail/wrap state in a small pointer RAM. One item at a time is worked
// through a read-modify-write sequencer; results leave via an output register.
// ----------------------------------------------------------------------------
`include "multi_queue_tx_message_fifo_defines.svh"

module multi_queue_tx_message_fifo
  import mqtx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // item input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic [QSEL_W-1:0]      in_queue_select,
  input  logic [ID_W-1:0]        in_message_id,
  input  logic [PAYLOAD_W-1:0]   in_payload,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [QSEL_W-1:0]      out_queue_number,
  output logic [ID_W-1:0]        out_tx_id,
  output logic [PAYLOAD_W-1:0]   out_tx_payload,
  output logic                   out_refused_full,
  output logic                   out_last,
  // config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // pointer width, queue index widths, RAM shapes
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QR        = (QW > QSEL_W) ? QW : QSEL_W;
  localparam int DW        = $clog2(QUEUE_DEPTH + 1);
  localparam int PE_W      = 2 * PTR_W + 1;
  localparam int MSG_W     = ID_W + PAYLOAD_W;
  localparam int MSG_DEPTH = 1 << (QW + PTR_W);
  localparam int PQ_DEPTH  = 1 << QW;

  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for an item
    ST_PDEC,   // pointer entry on the RAM output
    ST_MDATA,  // message on the RAM output
    ST_EMIT    // final beat waits for the output register
  } state_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [QR-1:0]          q_r, q_nxt;
  logic [ACTIVE_W-1:0]    visit_r, visit_nxt;
  logic                   pend_r, pend_nxt;        // res_r holds an unsent message
  logic                   ptr_rd_ok_r, ptr_rd_ok_nxt;
  logic [NUM_QUEUES-1:0]  pvalid_r, pvalid_nxt;    // pointer entry written since reset
  logic                   out_valid_r, out_valid_nxt;
  logic [DEPTH_CFG_W-1:0] cfg_depth_r, cfg_depth_nxt;
  logic [ACTIVE_W-1:0]    cfg_active_r, cfg_active_nxt;

  // payload, no reset
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [PAYLOAD_W-1:0]   payload_r, payload_nxt;
  res_t                   res_r, res_nxt;
  res_t                   out_r, out_nxt;

  // RAM ports
  logic                          ptr_we, ptr_re;
  logic [QW-1:0]                 ptr_waddr, ptr_raddr;
  logic [PE_W-1:0]               ptr_wdata, ptr_rdata;
  logic                          msg_we, msg_re;
  logic [QW+PTR_W-1:0]           msg_waddr, msg_raddr;
  logic [MSG_W-1:0]              msg_wdata, msg_rdata;

  // decoded working values
  logic [DW-1:0]         eff_depth;
  logic [ACTIVE_W-1:0]   visit_in;
  logic [QR-1:0]         q_in;
  logic [QR-1:0]         q_inc;
  logic                  more_q;
  logic [PE_W-1:0]       pent;
  logic                  p_wrap;
  logic [PTR_W-1:0]      p_head, p_tail;
  logic [PTR_W:0]        head_inc, tail_inc;
  logic                  head_wraps, tail_wraps;
  logic [PTR_W-1:0]      head_n, tail_n;
  logic                  q_empty, q_full;
  logic                  out_free;
  logic                  out_load;
  logic                  in_take;

  mqtx_ram #(.WIDTH(PE_W), .DEPTH(PQ_DEPTH)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  mqtx_ram #(.WIDTH(MSG_W), .DEPTH(MSG_DEPTH)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wdata),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  // depth 0 acts as 1, anything past QUEUE_DEPTH clamps
  always_comb begin
    if (cfg_depth_r == '0) begin
      eff_depth = DW'(1);
    end else if (32'(cfg_depth_r) > QUEUE_DEPTH) begin
      eff_depth = DW'(QUEUE_DEPTH);
    end else begin
      eff_depth = DW'(cfg_depth_r);
    end
  end

  assign visit_in = (32'(cfg_active_r) > NUM_QUEUES) ? ACTIVE_W'(NUM_QUEUES) : cfg_active_r;
  assign q_in     = QR'(in_queue_select);
  assign q_inc    = q_r + QR'(1);
  assign more_q   = (32'(q_r) + 1) < 32'(visit_r);

  // pointer entry: {wrap, head, tail}; never-written entries read as zero
  assign pent   = ptr_rd_ok_r ? ptr_rdata : '0;
  assign p_wrap = pent[PE_W-1];
  assign p_head = pent[2*PTR_W-1:PTR_W];
  assign p_tail = pent[PTR_W-1:0];

  // a pointer at or past the last slot (depth minus one) wraps to zero on its next advance
  assign head_inc   = {1'b0, p_head} + (PTR_W+1)'(1);
  assign tail_inc   = {1'b0, p_tail} + (PTR_W+1)'(1);
  assign head_wraps = 32'(head_inc) >= 32'(eff_depth);
  assign tail_wraps = 32'(tail_inc) >= 32'(eff_depth);
  assign head_n     = head_wraps ? '0 : head_inc[PTR_W-1:0];
  assign tail_n     = tail_wraps ? '0 : tail_inc[PTR_W-1:0];

  assign q_empty = !p_wrap && (p_head >= p_tail);
  assign q_full  = p_wrap && (p_tail >= p_head);

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    q_nxt          = q_r;
    visit_nxt      = visit_r;
    pend_nxt       = pend_r;
    ptr_rd_ok_nxt  = ptr_rd_ok_r;
    pvalid_nxt     = pvalid_r;
    cfg_depth_nxt  = cfg_depth_r;
    cfg_active_nxt = cfg_active_r;
    id_nxt         = id_r;
    payload_nxt    = payload_r;
    res_nxt        = res_r;
    out_load       = 1'b0;

    ptr_we    = 1'b0;
    ptr_waddr = q_r[QW-1:0];
    ptr_wdata = '0;
    ptr_re    = 1'b0;
    ptr_raddr = q_r[QW-1:0];
    msg_we    = 1'b0;
    msg_waddr = {q_r[QW-1:0], p_tail};
    msg_wdata = {id_r, payload_r};
    msg_re    = 1'b0;
    msg_raddr = {q_r[QW-1:0], p_head};

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUEUE_DEPTH:   cfg_depth_nxt  = cfg_data[DEPTH_CFG_W-1:0];
        CFG_ACTIVE_QUEUES: cfg_active_nxt = cfg_data[ACTIVE_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt      = op_t'(in_operation);
          id_nxt      = in_message_id;
          payload_nxt = in_payload;
          pend_nxt    = 1'b0;
          if (op_t'(in_operation) == OP_DRAIN) begin
            q_nxt     = '0;
            visit_nxt = visit_in;
            if (visit_in == '0) begin
              res_nxt   = '{kind: KIND_EMPTY, qnum: '0, id: '0, payload: '0,
                            refused: 1'b0, last: 1'b1};
              state_nxt = ST_EMIT;
            end else begin
              ptr_re        = 1'b1;
              ptr_raddr     = '0;
              ptr_rd_ok_nxt = pvalid_r[0];
              state_nxt     = ST_PDEC;
            end
          end else begin
            q_nxt = q_in;
            if (32'(in_queue_select) >= NUM_QUEUES) begin
              // nonexistent queue: refused without touching any queue's pointers or messages
              res_nxt   = '{kind: KIND_STATUS, qnum: in_queue_select, id: '0,
                            payload: '0, refused: 1'b1, last: 1'b1};
              state_nxt = ST_EMIT;
            end else begin
              ptr_re        = 1'b1;
              ptr_raddr     = q_in[QW-1:0];
              ptr_rd_ok_nxt = pvalid_r[q_in[QW-1:0]];
              state_nxt     = ST_PDEC;
            end
          end
        end
      end

      ST_PDEC: begin
        if (op_r == OP_ENQUEUE) begin
          res_nxt   = '{kind: KIND_STATUS, qnum: q_r[QSEL_W-1:0], id: '0,
                        payload: '0, refused: q_full, last: 1'b1};
          state_nxt = ST_EMIT;
          if (!q_full) begin
            msg_we                  = 1'b1;
            ptr_we                  = 1'b1;
            ptr_wdata               = {p_wrap | tail_wraps, p_head, tail_n};
            pvalid_nxt[q_r[QW-1:0]] = 1'b1;
          end
        end else if (!q_empty) begin
          // pop: write back head, fetch the message
          ptr_we                  = 1'b1;
          ptr_wdata               = {p_wrap & !head_wraps, head_n, p_tail};
          pvalid_nxt[q_r[QW-1:0]] = 1'b1;
          msg_re                  = 1'b1;
          state_nxt               = ST_MDATA;
        end else if (more_q) begin
          q_nxt         = q_inc;
          ptr_re        = 1'b1;
          ptr_raddr     = q_inc[QW-1:0];
          ptr_rd_ok_nxt = pvalid_r[q_inc[QW-1:0]];
        end else begin
          if (pend_r) begin
            res_nxt.last = 1'b1;
          end else begin
            res_nxt = '{kind: KIND_EMPTY, qnum: '0, id: '0, payload: '0,
                        refused: 1'b0, last: 1'b1};
          end
          state_nxt = ST_EMIT;
        end
      end

      ST_MDATA: begin
        // a held message goes out (not last) before the new one takes its place
        if (!pend_r || out_free) begin
          out_load = pend_r;
          res_nxt  = '{kind: KIND_MSG, qnum: q_r[QSEL_W-1:0],
                       id: msg_rdata[MSG_W-1 -: ID_W],
                       payload: msg_rdata[PAYLOAD_W-1:0],
                       refused: 1'b0, last: 1'b0};
          pend_nxt = 1'b1;
          if (more_q) begin
            q_nxt         = q_inc;
            ptr_re        = 1'b1;
            ptr_raddr     = q_inc[QW-1:0];
            ptr_rd_ok_nxt = pvalid_r[q_inc[QW-1:0]];
            state_nxt     = ST_PDEC;
          end else begin
            res_nxt.last = 1'b1;
            state_nxt    = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_nxt = out_load ? res_r : out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_ENQUEUE;
      q_r          <= '0;
      visit_r      <= '0;
      pend_r       <= 1'b0;
      ptr_rd_ok_r  <= 1'b0;
      pvalid_r     <= '0;
      out_valid_r  <= 1'b0;
      cfg_depth_r  <= QUEUE_DEPTH_RST;
      cfg_active_r <= ACTIVE_QUEUES_RST;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      q_r          <= q_nxt;
      visit_r      <= visit_nxt;
      pend_r       <= pend_nxt;
      ptr_rd_ok_r  <= ptr_rd_ok_nxt;
      pvalid_r     <= pvalid_nxt;
      out_valid_r  <= out_valid_nxt;
      cfg_depth_r  <= cfg_depth_nxt;
      cfg_active_r <= cfg_active_nxt;
    end
    id_r      <= id_nxt;
    payload_r <= payload_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_queue_number = out_r.qnum;
  assign out_tx_id        = out_r.id;
  assign out_tx_payload   = out_r.payload;
  assign out_refused_full = out_r.refused;
  assign out_last         = out_r.last;

  // never overwrite a beat that is still waiting
  `MQTX_ASSERT_NOW(a_out_no_overwrite, out_load, !out_valid_r || !out_stall, "beat overwritten")
  // pointer read-modify-write never reads the entry it writes in the same cycle
  `MQTX_ASSERT_NOW(a_ptr_no_collide, ptr_re && ptr_we, ptr_raddr != ptr_waddr, "ptr collision")
  // a held message only exists during a drain
  `MQTX_ASSERT_NOW(a_pend_drain, pend_r, op_r == OP_DRAIN, "pending message outside drain")
  // an accepted item always starts the sequencer
  `MQTX_ASSERT_NEXT(a_take_busy, in_take, state_r != ST_IDLE, "item accepted but sequencer idle")
  // the message RAM is written only from the pointer decode step
  `MQTX_ASSERT_NOW(a_msg_we_pdec, msg_we, state_r == ST_PDEC && op_r == OP_ENQUEUE, "stray write")

endmodule

/* sv/mqtx_ram.sv */
// ----------------------------------------------------------------------------
// mqtx_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mqtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
